// ===== hdl/mlfe_pkg.sv =====
// Shared types, constants and the delay line length table of the feedback echo unit.
package mlfe_pkg;

   localparam int SMP_W     = 24;   // widest sample carried along the cell chain
   localparam int ACC_W     = 40;   // running sum of sample and line values
   localparam int HIST_W    = 32;   // one stored history value
   localparam int DECAY_W   = 10;
   localparam int CNT_W     = 5;
   localparam int QUO_W     = 22;   // history magnitude over 1000
   localparam int REM_W     = 10;   // remainder of that division
   localparam int SMALL_W   = 20;   // remainder times decay
   localparam int QPROD_W   = 59;   // eighth of the magnitude times its reciprocal
   localparam int RPROD_W   = 35;   // eighth of the small product times its reciprocal
   localparam int MAX_LINES = 20;
   localparam logic [DECAY_W-1:0] DECAY_DEN   = 10'd1000;
   localparam logic [DECAY_W-1:0] DECAY_RESET = 10'd700;
   localparam logic [CNT_W-1:0]   LINES_RESET = 5'd20;

   // Division by 125 after a shift by three, as multiplication by a rounded-up reciprocal.
   localparam logic [29:0] RECIP_Q = 30'd549755814;   // 2**36 / 125, rounded up
   localparam int          Q_SHIFT = 36;
   localparam logic [17:0] RECIP_R = 18'd134218;      // 2**24 / 125, rounded up
   localparam int          R_SHIFT = 24;

   // Register indexes on the configuration port.
   localparam logic REG_DECAY = 1'b0;
   localparam logic REG_LINES = 1'b1;

   // Sample token handed from cell to cell.
   typedef struct packed {
      logic                    start;
      logic signed [SMP_W-1:0] x;
   } mlfe_tok_type;

   // Partial sum handed from cell to cell.
   typedef struct packed {
      logic                    valid;
      logic signed [ACC_W-1:0] sum;
   } mlfe_acc_type;

   // Every second prime from 13 upward.
   function automatic int unsigned line_factor(input int unsigned j);
      int unsigned f;
      case (j)
         0:       f = 13;
         1:       f = 19;
         2:       f = 29;
         3:       f = 37;
         4:       f = 43;
         5:       f = 53;
         6:       f = 61;
         7:       f = 71;
         8:       f = 79;
         9:       f = 89;
         10:      f = 101;
         11:      f = 107;
         12:      f = 113;
         13:      f = 131;
         14:      f = 139;
         15:      f = 151;
         16:      f = 163;
         17:      f = 173;
         18:      f = 181;
         default: f = 193;
      endcase
      return f;
   endfunction

endpackage

// ===== hdl/mlfe_ram.sv =====
// Generic single write port RAM with one registered read port.
module mlfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/mlfe_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module mlfe_div #(
   parameter int NW = 40,
   parameter int DW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] div_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic          fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NW-1]};
      fits    = trial >= {1'b0, div_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NW-2:0], fits};
         rem_in = fits ? DW'(trial - {1'b0, div_ff}) : DW'(trial);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) begin
         div_ff <= divisor;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== hdl/mlfe_cell.sv =====
// One feedback delay line: its store, position, decay update and partial sum stage.
module mlfe_cell
   import mlfe_pkg::*;
#(
   parameter int LINE_LEN = 208
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic [DECAY_W-1:0] decay,
   input  mlfe_tok_type       tok_in,
   output mlfe_tok_type       tok_out,
   input  mlfe_acc_type       acc_in,
   output mlfe_acc_type       acc_out,
   output logic               cleared
);
   localparam int AW = $clog2(LINE_LEN);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_QUO   = 3'd2;
   localparam logic [2:0] S_REM   = 3'd3;
   localparam logic [2:0] S_SCALE = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;
   localparam logic [2:0] S_WB    = 3'd6;

   logic [2:0]               state_ff, state_in;
   logic [AW-1:0]            pos_ff, clr_cnt_ff;
   logic                     cleared_ff;
   logic signed [SMP_W-1:0]  x_ff;
   logic [DECAY_W-1:0]       decay_ff;
   logic [HIST_W-1:0]        mag_ff, mag_in;
   logic                     neg_ff;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [HIST_W-1:0]        big_ff, big_in;
   logic [SMALL_W-1:0]       small_ff, small_in;
   logic signed [HIST_W-1:0] hnew_ff, hnew_in;
   logic signed [HIST_W-1:0] res_val_ff;
   logic                     res_have_ff, acc_have_ff;
   logic signed [ACC_W-1:0]  acc_hold_ff;
   mlfe_tok_type             tok_ff;
   mlfe_acc_type             acc_ff;

   logic [HIST_W-1:0]        rd_data;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [HIST_W-1:0]        wr_data;
   logic [QPROD_W-1:0]       qprod;
   logic [RPROD_W-1:0]       rprod;
   logic [REM_W-1:0]         low_prod;
   logic [REM_W-1:0]         frac;
   logic [HIST_W-1:0]        q_mag;
   logic signed [33:0]       q_s, sum_s;
   logic                     fire;

   mlfe_ram #(.WIDTH(HIST_W), .DEPTH(LINE_LEN)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   // The magnitude of h*decay/1000 is split as |h| = 1000*q + r, giving
   // q*decay + (r*decay)/1000; both divisions use reciprocal multiplication.
   always_comb begin
      mag_in   = rd_data[HIST_W-1] ? -rd_data : rd_data;
      qprod    = {{(QPROD_W-(HIST_W-3)){1'b0}}, mag_ff[HIST_W-1:3]}
               * {{(QPROD_W-30){1'b0}}, RECIP_Q};
      quo_in   = qprod[Q_SHIFT +: QUO_W];
      low_prod = quo_ff[REM_W-1:0] * DECAY_DEN;
      rem_in   = mag_ff[REM_W-1:0] - low_prod;
      big_in   = {{(HIST_W-QUO_W){1'b0}}, quo_ff} * {{(HIST_W-DECAY_W){1'b0}}, decay_ff};
      small_in = {{(SMALL_W-REM_W){1'b0}}, rem_ff} * {{(SMALL_W-DECAY_W){1'b0}}, decay_ff};
      rprod    = {{(RPROD_W-(SMALL_W-3)){1'b0}}, small_ff[SMALL_W-1:3]}
               * {{(RPROD_W-18){1'b0}}, RECIP_R};
      frac     = rprod[R_SHIFT +: REM_W];
      q_mag    = big_ff + {{(HIST_W-REM_W){1'b0}}, frac};
      q_s      = $signed({2'b00, q_mag});
      if (neg_ff) begin
         q_s = -q_s;
      end
      sum_s = q_s + 34'($signed(x_ff));
      if (sum_s > 34'sh0_7FFF_FFFF) begin
         hnew_in = 32'sh7FFF_FFFF;
      end else if (sum_s < -34'sh0_8000_0000) begin
         hnew_in = -32'sh8000_0000;
      end else begin
         hnew_in = sum_s[HIST_W-1:0];
      end
      wr_en   = !cleared_ff || (state_ff == S_WB);
      wr_addr = cleared_ff ? pos_ff : clr_cnt_ff;
      wr_data = cleared_ff ? hnew_ff : '0;
      fire    = res_have_ff && acc_have_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (tok_in.start && enable) state_in = S_READ;
         S_READ:  state_in = S_QUO;
         S_QUO:   state_in = S_REM;
         S_REM:   state_in = S_SCALE;
         S_SCALE: state_in = S_FIN;
         S_FIN:   state_in = S_WB;
         S_WB:    state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      if (tok_in.start) begin
         x_ff     <= tok_in.x;
         decay_ff <= decay;
      end
      mag_ff   <= mag_in;
      neg_ff   <= rd_data[HIST_W-1];
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      big_ff   <= big_in;
      small_ff <= small_in;
      hnew_ff  <= hnew_in;
      if (acc_in.valid) begin
         acc_hold_ff <= acc_in.sum;
      end
      acc_ff.sum <= acc_hold_ff + ACC_W'(res_val_ff);
      if (tok_in.start && !enable) begin
         res_val_ff <= '0;
      end else if (state_ff == S_WB) begin
         res_val_ff <= hnew_ff;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         clr_cnt_ff   <= '0;
         cleared_ff   <= 1'b0;
         res_have_ff  <= 1'b0;
         acc_have_ff  <= 1'b0;
         acc_ff.valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (!cleared_ff) begin
            if (clr_cnt_ff == AW'(LINE_LEN - 1)) begin
               cleared_ff <= 1'b1;
            end else begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
            end
         end
         if (state_ff == S_WB) begin
            pos_ff <= (pos_ff == AW'(LINE_LEN - 1)) ? '0 : pos_ff + 1'b1;
         end
         acc_ff.valid <= fire;
         if (fire) begin
            res_have_ff <= 1'b0;
            acc_have_ff <= 1'b0;
         end else begin
            if ((tok_in.start && !enable) || state_ff == S_WB) begin
               res_have_ff <= 1'b1;
            end
            if (acc_in.valid) begin
               acc_have_ff <= 1'b1;
            end
         end
      end
   end

   assign tok_out = tok_ff;
   assign acc_out = acc_ff;
   assign cleared = cleared_ff;
endmodule

// ===== hdl/multi_line_feedback_echo_unit.sv =====
// Top level of the multi-line feedback echo unit: channels, configuration and output divide.
//
// Usage: one signed sample per request enters on the req_ stream (req_tdata holds in_sample)
// and exactly one echoed sample leaves on the rsp_ stream (rsp_tdata holds out_sample).
// The sample is handed along a row of NUM_LINES cells, one cell per cycle; each cell owns
// one delay line in its own RAM. A cell within the line count applies h = h*decay/1000 + x
// in its read, quotient, remainder, scale, finish and write-back states, dividing by the
// constant through reciprocal multiplications; a cell beyond the count gives zero. Each
// cell adds its value to the partial sum once it holds both that value and the sum from
// the previous cell. The final sum then goes through the signed divide by twice the line
// count, one quotient bit a cycle. The block works on one request at a time: the next one
// is taken only after the last has left the divider and its result is in the output
// register. After reset every cell sweeps its line to zero, one entry a cycle, and no
// request is taken until all lines are clear. Configuration (decay at byte 0, line count
// at byte 4) is written over the csr_ port; the user must write it only while the block is
// idle, which the block itself does not enforce. When the receiver stalls, the result
// stays in the output register and one more request may still be taken; its result is
// then held back until the output register is free, and no further request is taken
// meanwhile.
module multi_line_feedback_echo_unit
   import mlfe_pkg::*;
#(
   parameter int NUM_LINES   = 20,
   parameter int LINE_BASE   = 16,
   parameter int SAMPLE_BITS = 16,
   localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,     // in_sample
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,     // out_sample
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   localparam logic [1:0] T_IDLE  = 2'd0;
   localparam logic [1:0] T_RUN   = 2'd1;
   localparam logic [1:0] T_DIV   = 2'd2;
   localparam logic [1:0] T_OUT   = 2'd3;
   localparam logic signed [ACC_W:0] SMAX = (ACC_W+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [ACC_W:0] SMIN = -SMAX - 1;

   logic [1:0]               state_ff, state_in;
   logic [DECAY_W-1:0]       decay_ff;
   logic [CNT_W-1:0]         lines_ff, n_eff;
   logic signed [ACC_W-1:0]  sum_ff;
   logic                     start_ff;
   logic [SAMPLE_BITS-1:0]   rsp_data_ff;
   logic                     rsp_valid_ff;
   logic                     csr_wr, accept, load, all_clear;
   logic [NUM_LINES-1:0]     cleared;
   logic signed [SMP_W-1:0]  x_in;
   logic signed [SMP_W+CNT_W:0] start_sum;
   logic signed [ACC_W-1:0]  abs_sum;
   logic [ACC_W-1:0]         quo;
   logic                     div_done;
   logic signed [ACC_W:0]    res;
   logic [SAMPLE_BITS-1:0]   res_sat;
   mlfe_tok_type             tok [NUM_LINES+1];
   mlfe_acc_type             acc [NUM_LINES+1];

   // Configuration registers.
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[2])
         REG_DECAY: csr_prdata = {{(32-DECAY_W){1'b0}}, decay_ff};
         REG_LINES: csr_prdata = {{(32-CNT_W){1'b0}}, lines_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // A line count of zero acts as one; above the bank size it acts as the bank size.
   always_comb begin
      if (lines_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (lines_ff > CNT_W'(NUM_LINES)) begin
         n_eff = CNT_W'(NUM_LINES);
      end else begin
         n_eff = lines_ff;
      end
   end

   assign all_clear  = &cleared;
   assign req_tready = (state_ff == T_IDLE) && all_clear;
   assign accept     = req_tvalid && req_tready;
   assign x_in       = SMP_W'($signed(req_tdata[SAMPLE_BITS-1:0]));

   // The sample enters the first cell together with the starting sum x*n.
   assign start_sum    = x_in * $signed({1'b0, n_eff});
   assign tok[0].start = accept;
   assign tok[0].x     = x_in;
   assign acc[0].valid = accept;
   assign acc[0].sum   = ACC_W'(start_sum);

   for (genvar j = 0; j < NUM_LINES; j++) begin : g_cell
      mlfe_cell #(.LINE_LEN(int'(line_factor(j)) * LINE_BASE)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (CNT_W'(j) < n_eff),
         .decay   (decay_ff),
         .tok_in  (tok[j]),
         .tok_out (tok[j+1]),
         .acc_in  (acc[j]),
         .acc_out (acc[j+1]),
         .cleared (cleared[j])
      );
   end

   // Final divide by 2n, truncating toward zero, on the magnitude of the sum.
   assign abs_sum = sum_ff[ACC_W-1] ? -sum_ff : sum_ff;

   mlfe_div #(.NW(ACC_W), .DW(CNT_W+1)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (abs_sum),
      .divisor  ({n_eff, 1'b0}),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      res = $signed({1'b0, quo});
      if (sum_ff[ACC_W-1]) begin
         res = -res;
      end
      if (res > SMAX) begin
         res_sat = SAMPLE_BITS'(SMAX);
      end else if (res < SMIN) begin
         res_sat = SAMPLE_BITS'(SMIN);
      end else begin
         res_sat = res[SAMPLE_BITS-1:0];
      end
   end

   assign load = (state_ff == T_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE:  if (accept) state_in = T_RUN;
         T_RUN:   if (acc[NUM_LINES].valid) state_in = T_DIV;
         T_DIV:   if (div_done) state_in = T_OUT;
         T_OUT:   if (load) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (acc[NUM_LINES].valid) begin
         sum_ff <= acc[NUM_LINES].sum;
      end
      if (load) begin
         rsp_data_ff <= res_sat;
      end
      if (reset) begin
         state_ff     <= T_IDLE;
         decay_ff     <= DECAY_RESET;
         lines_ff     <= LINES_RESET;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= (state_ff == T_RUN) && acc[NUM_LINES].valid;
         if (csr_wr && csr_paddr[2] == REG_DECAY) begin
            decay_ff <= csr_pwdata[DECAY_W-1:0];
         end
         if (csr_wr && csr_paddr[2] == REG_LINES) begin
            lines_ff <= csr_pwdata[CNT_W-1:0];
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);

`ifndef SYNTHESIS
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == T_RUN)
      else $error("accepted request did not start the cell row");
   a_sum_in_run: assert property (@(posedge clock) disable iff (reset)
      acc[NUM_LINES].valid |-> state_ff == T_RUN)
      else $error("line sum arrived outside a running request");
   a_no_req_clearing: assert property (@(posedge clock) disable iff (reset)
      !all_clear |-> !req_tready)
      else $error("request taken while delay lines are being cleared");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == T_DIV)
      else $error("output divider finished outside its state");
`endif
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the multi-line feedback echo unit.
module tb_top
   import mlfe_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINES = 20;
   localparam int BASE  = 16;
   localparam int SBITS = 16;
   localparam int DEPTH = 1946 * BASE;
   localparam logic [2:0] ADDR_DECAY = 3'd0;
   localparam logic [2:0] ADDR_LINES = 3'd4;
   localparam int WATCHDOG = 200000;

   // Predicts the echoed sample of each accepted request and checks results in order.
   class echo_scoreboard;
      int            errors;
      logic [9:0]    decay;
      logic [4:0]    lines;
      int            store [DEPTH];
      int unsigned   pos [LINES];
      logic [15:0]   pending [$];

      function void clear();
         foreach (store[i]) store[i] = 0;
         foreach (pos[i]) pos[i] = 0;
         decay = DECAY_RESET;
         lines = LINES_RESET;
         errors = 0;
      endfunction

      function void note_request(logic [15:0] smp);
         longint x, acc, h, res;
         int unsigned n, len, b, a;
         x = longint'($signed(smp));
         n = lines;
         if (n < 1) n = 1;
         if (n > LINES) n = LINES;
         acc = x * n;
         b = 0;
         for (int j = 0; j < n; j++) begin
            len = line_factor(j) * BASE;
            if (pos[j] >= len) pos[j] = 0;
            a = b + pos[j];
            h = longint'(store[a]);
            h = (h * longint'(decay)) / 1000 + x;
            if (h > 64'sd2147483647) h = 64'sd2147483647;
            if (h < -64'sd2147483648) h = -64'sd2147483648;
            store[a] = int'(h);
            acc += h;
            pos[j] = (pos[j] + 1 >= len) ? 0 : pos[j] + 1;
            b += len;
         end
         res = acc / (2 * longint'(n));
         if (res > 32767) res = 32767;
         if (res < -32768) res = -32768;
         pending.push_back(res[15:0]);
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(logic [15:0] got);
         logic [15:0] want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result %h", got));
         end else begin
            want = pending.pop_front();
            if (got !== want) report($sformatf("out_sample %h, expected %h", got, want));
         end
      endtask
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [15:0] req_tdata, rsp_tdata;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   echo_scoreboard echo_sb;
   int          idle_cycles;
   int          stall_left;
   bit          stall_free;  // receiver never stalls while set

   multi_line_feedback_echo_unit uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap lengths: mostly short, sometimes long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 120);
   endfunction

   // The receiver stalls for random stretches; stalls are sampled at the same edge as the
   // handshake.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) echo_sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready) idle_cycles <= 0;
         else if (rsp_tvalid && rsp_tready) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (stall_free) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_tready <= 1'b1;
            stall_left <= gap_len();
         end
      end
   end

   // A register write: setup cycle, then the access cycle, done when pready is seen high.
   task csr_write(logic [2:0] addr, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_DECAY) echo_sb.decay = data[9:0];
      else if (addr == ADDR_LINES) echo_sb.lines = data[4:0];
   endtask

   // Sends one request after a random gap and holds it until it is taken.
   task send_request(logic [15:0] smp);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      do @(posedge clock); while (!req_tready);
      echo_sb.note_request(smp);
   endtask

   // Waits until every predicted result has come back, then lets the row drain.
   task drain();
      req_tvalid <= 1'b0;
      while (echo_sb.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // Random samples: extremes and small values near zero now and then, otherwise anything.
   function automatic logic [15:0] pick_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h7fff;
      if (r == 1) return 16'h8000;
      if (r == 2) return 16'($urandom_range(0, 15)) - 16'd8;
      return 16'($urandom);
   endfunction

   // Watchdog: counts cycles with no handshake on either stream.
   always @(posedge clock) begin
      if (!reset && idle_cycles >= WATCHDOG) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [9:0] decays [5];
      logic [4:0] counts [5];
      echo_sb = new();
      echo_sb.clear();
      idle_cycles = 0;
      stall_free  = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings: sample extremes, zero, minus one, one and two alternating bit patterns.
      send_request(16'h7fff);
      send_request(16'h8000);
      send_request(16'h0000);
      send_request(16'hffff);
      send_request(16'h0001);
      send_request(16'h5555);
      send_request(16'haaaa);
      drain();
      // Zero line count acts as one, a count above twenty as twenty.
      csr_write(ADDR_LINES, 32'd0);
      send_request(16'h7fff);
      send_request(16'h8000);
      drain();
      csr_write(ADDR_LINES, 32'd31);
      // Decay above a thousand, fed with full-scale and near full-scale input.
      csr_write(ADDR_DECAY, 32'd1023);
      for (int i = 0; i < 10; i++) send_request(i[0] ? 16'h7fff : 16'h7ffe);
      drain();

      // Random phases through a spread of settings, extremes included.
      decays = '{10'd10, 10'd1000, 10'd1023, 10'd500, 10'd700};
      counts = '{5'd1, 5'd20, 5'd7, 5'd13, 5'd0};
      for (int ph = 0; ph < 10; ph++) begin
         csr_write(ADDR_DECAY, ph < 5 ? decays[ph] : $urandom_range(0, 1023));
         csr_write(ADDR_LINES, ph < 5 ? counts[ph] : $urandom_range(0, 31));
         stall_free = (ph == 3);
         for (int i = 0; i < 70; i++) send_request(pick_sample());
         drain();
      end

      if (echo_sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/mlfe_pkg.sv
hdl/mlfe_ram.sv
hdl/mlfe_div.sv
hdl/mlfe_cell.sv
hdl/multi_line_feedback_echo_unit.sv
sim/tb_top.sv
